/* rtl/core/slx_pkg.sv */
// Shared types, character codes and the word table for the source lexer.
package slx_pkg;

    localparam int LINE_BITS_DEFAULT = 32;
    localparam int TOKEN_LINE_W      = 32;

    localparam int NWORDS       = 14;
    localparam int NUM_KEYWORDS = 3;

    localparam int OUTQ_DEPTH = 4;
    localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
    localparam int QLVL_W     = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_SLASH    = 4'd1,
        MODE_LCOMMENT = 4'd2,
        MODE_BLOCK    = 4'd3,
        MODE_BSTAR    = 4'd4,
        MODE_IDENT    = 4'd5,
        MODE_NUMBER   = 4'd6,
        MODE_STRING   = 4'd7,
        MODE_ESC      = 4'd8
    } lex_mode_t;

    localparam logic [2:0] KIND_SYM  = 3'd0;
    localparam logic [2:0] KIND_OP   = 3'd1;
    localparam logic [2:0] KIND_STR  = 3'd2;
    localparam logic [2:0] KIND_KEY  = 3'd3;
    localparam logic [2:0] KIND_PRIM = 3'd4;
    localparam logic [2:0] KIND_ID   = 3'd5;
    localparam logic [2:0] KIND_NUM  = 3'd6;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // words right-justified: first character is the most significant byte in use
    localparam logic [63:0] WORD_TEXT [NWORDS] = '{
        64'("func"), 64'("struct"), 64'("return"), 64'("int8"), 64'("uint8"),
        64'("int16"), 64'("uint16"), 64'("int32"), 64'("uint32"), 64'("int64"),
        64'("uint64"), 64'("float32"), 64'("float64"), 64'("string")
    };
    localparam logic [3:0] WORD_LEN [NWORDS] = '{
        4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7, 4'd6
    };

    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
    } slx_in_t;

    typedef struct packed {
        logic [2:0]              token_kind;
        logic [7:0]              value_byte;
        logic                    byte_valid;
        logic                    token_last;
        logic [TOKEN_LINE_W-1:0] token_line;
        logic                    escape_error;
    } slx_out_t;

    typedef struct packed {
        logic [1:0] count;
        slx_out_t   first;
        slx_out_t   second;
    } slx_push_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              has_room;
        logic              not_empty;
    } slx_q_status_t;

    function automatic logic [NWORDS-1:0] word_match(input logic [NWORDS-1:0] cand,
                                                     input logic [3:0] len,
                                                     input logic [7:0] c);
        logic [NWORDS-1:0] keep;
        logic [2:0]        pos;
        keep = cand;
        for (int w = 0; w < NWORDS; w++) begin
            pos = 3'(WORD_LEN[w] - len - 4'd1);
            if (!(len < WORD_LEN[w] && WORD_TEXT[w][{pos, 3'b000} +: 8] == c)) begin
                keep[w] = 1'b0;
            end
        end
        return keep;
    endfunction

    function automatic logic [2:0] ident_kind(input logic [NWORDS-1:0] cand,
                                              input logic [3:0] len);
        logic [2:0] kind;
        kind = KIND_ID;
        for (int w = NWORDS - 1; w >= 0; w--) begin
            if (cand[w] && WORD_LEN[w] == len) begin
                kind = (w < NUM_KEYWORDS) ? KIND_KEY : KIND_PRIM;
            end
        end
        return kind;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_SEMI || c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c == CH_EQUALS || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
            || c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    // {known, decoded byte}
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            CH_N:      r = {1'b1, CH_NL};
            CH_T:      r = {1'b1, CH_TAB};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_V:      r = {1'b1, CH_VT};
            CH_R:      r = {1'b1, CH_CR};
            CH_F:      r = {1'b1, CH_FF};
            CH_0:      r = {1'b1, CH_NUL};
            default:   r = {1'b0, CH_NUL};
        endcase
        return r;
    endfunction

    function automatic slx_out_t make_result(input logic [2:0] kind, input logic [7:0] b,
                                             input logic valid, input logic last,
                                             input logic [TOKEN_LINE_W-1:0] line,
                                             input logic err);
        slx_out_t r;
        r.token_kind   = kind;
        r.value_byte   = valid ? b : 8'h00;
        r.byte_valid   = valid;
        r.token_last   = last;
        r.token_line   = line;
        r.escape_error = err;
        return r;
    endfunction

endpackage

/* rtl/core/slx_core.sv */
// Lexer state registers and per-item decode into up to two results.
module slx_core #(
    parameter int LINE_BITS = slx_pkg::LINE_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  slx_pkg::slx_in_t   item,
    output slx_pkg::slx_push_t push
);
    import slx_pkg::*;

    lex_mode_t             mode_reg, mode_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [LINE_BITS-1:0]  start_reg, start_next;
    logic [NWORDS-1:0]     cand_reg, cand_next;
    logic [3:0]            len_reg, len_next;

    logic [7:0]            c;
    logic                  flush;
    logic [8:0]            esc;
    logic [LINE_BITS-1:0]  line_inc;
    logic [3:0]            len_inc;
    logic [TOKEN_LINE_W-1:0] start_tl, line_tl;
    logic                  idle_go;
    logic                  a_v, b_v;
    slx_out_t              a_res, b_res;

    function automatic logic [TOKEN_LINE_W-1:0] to_token_line(input logic [LINE_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > 64'({TOKEN_LINE_W{1'b1}})) begin
            return '1;
        end
        return wide[TOKEN_LINE_W-1:0];
    endfunction

    assign c        = item.char_in;
    assign flush    = (item.command == CMD_FLUSH);
    assign esc      = escape_value(c);
    assign line_inc = (&line_reg) ? line_reg : line_reg + LINE_BITS'(1);
    assign len_inc  = (&len_reg) ? len_reg : len_reg + 4'd1;
    assign start_tl = to_token_line(start_reg);
    assign line_tl  = to_token_line(line_reg);

    // results
    always_comb begin
        a_v     = 1'b0;
        a_res   = make_result(KIND_SYM, CH_NUL, 1'b0, 1'b0, start_tl, 1'b0);
        b_v     = 1'b0;
        b_res   = make_result(KIND_SYM, CH_NUL, 1'b0, 1'b0, line_tl, 1'b0);
        idle_go = 1'b0;
        if (flush) begin
            unique case (mode_reg)
                MODE_SLASH: begin
                    a_v   = 1'b1;
                    a_res = make_result(KIND_OP, CH_SLASH, 1'b1, 1'b1, start_tl, 1'b0);
                end
                MODE_IDENT: begin
                    a_v   = 1'b1;
                    a_res = make_result(ident_kind(cand_reg, len_reg), CH_NUL, 1'b0, 1'b1,
                                        start_tl, 1'b0);
                end
                MODE_NUMBER: begin
                    a_v   = 1'b1;
                    a_res = make_result(KIND_NUM, CH_NUL, 1'b0, 1'b1, start_tl, 1'b0);
                end
                MODE_STRING: begin
                    a_v   = 1'b1;
                    a_res = make_result(KIND_STR, CH_NUL, 1'b0, 1'b1, start_tl, 1'b0);
                end
                MODE_ESC: begin
                    a_v   = 1'b1;
                    a_res = make_result(KIND_STR, CH_NUL, 1'b0, 1'b1, start_tl, 1'b1);
                end
                default: ;
            endcase
        end else begin
            unique case (mode_reg)
                MODE_SLASH: begin
                    if (c != CH_SLASH && c != CH_STAR) begin
                        a_v     = 1'b1;
                        a_res   = make_result(KIND_OP, CH_SLASH, 1'b1, 1'b1, start_tl, 1'b0);
                        idle_go = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    a_v = 1'b1;
                    if (is_alpha(c) || is_digit(c)) begin
                        a_res = make_result(KIND_ID, c, 1'b1, 1'b0, start_tl, 1'b0);
                    end else begin
                        a_res   = make_result(ident_kind(cand_reg, len_reg), CH_NUL, 1'b0,
                                              1'b1, start_tl, 1'b0);
                        idle_go = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    a_v = 1'b1;
                    if (is_digit(c) || c == CH_DOT) begin
                        a_res = make_result(KIND_NUM, c, 1'b1, 1'b0, start_tl, 1'b0);
                    end else begin
                        a_res   = make_result(KIND_NUM, CH_NUL, 1'b0, 1'b1, start_tl, 1'b0);
                        idle_go = 1'b1;
                    end
                end
                MODE_LCOMMENT, MODE_BLOCK, MODE_BSTAR: ;
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        a_v   = 1'b1;
                        a_res = make_result(KIND_STR, CH_NUL, 1'b0, 1'b1, start_tl, 1'b0);
                    end else if (c != CH_BSLASH) begin
                        a_v   = 1'b1;
                        a_res = make_result(KIND_STR, c, 1'b1, 1'b0, start_tl, 1'b0);
                    end
                end
                MODE_ESC: begin
                    a_v = 1'b1;
                    if (esc[8]) begin
                        a_res = make_result(KIND_STR, esc[7:0], 1'b1, 1'b0, start_tl, 1'b0);
                    end else begin
                        a_res = make_result(KIND_STR, CH_NUL, 1'b0, 1'b0, start_tl, 1'b1);
                    end
                end
                default: idle_go = 1'b1;
            endcase
            if (idle_go) begin
                if (is_symbol(c)) begin
                    b_v   = 1'b1;
                    b_res = make_result(KIND_SYM, c, 1'b1, 1'b1, line_tl, 1'b0);
                end else if (is_operator(c)) begin
                    b_v   = 1'b1;
                    b_res = make_result(KIND_OP, c, 1'b1, 1'b1, line_tl, 1'b0);
                end else if (is_alpha(c)) begin
                    b_v   = 1'b1;
                    b_res = make_result(KIND_ID, c, 1'b1, 1'b0, line_tl, 1'b0);
                end else if (is_digit(c)) begin
                    b_v   = 1'b1;
                    b_res = make_result(KIND_NUM, c, 1'b1, 1'b0, line_tl, 1'b0);
                end
            end
        end
    end

    // next state
    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        start_next = start_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        if (flush) begin
            mode_next  = MODE_IDLE;
            line_next  = LINE_BITS'(1);
            start_next = LINE_BITS'(1);
            cand_next  = '1;
            len_next   = 4'd0;
        end else begin
            unique case (mode_reg)
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_LCOMMENT;
                    end else if (c == CH_STAR) begin
                        mode_next = MODE_BLOCK;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        cand_next = word_match(cand_reg, len_reg, c);
                        len_next  = len_inc;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (!(is_digit(c) || c == CH_DOT)) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_LCOMMENT: begin
                    if (c == CH_NL) begin
                        line_next = line_inc;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK: begin
                    if (c == CH_STAR) begin
                        mode_next = MODE_BSTAR;
                    end else if (c == CH_NL) begin
                        line_next = line_inc;
                    end
                end
                MODE_BSTAR: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_IDLE;
                    end else if (c != CH_STAR) begin
                        if (c == CH_NL) begin
                            line_next = line_inc;
                        end
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else if (c == CH_NL) begin
                        line_next = line_inc;
                    end
                end
                MODE_ESC: begin
                    if (!esc[8] && c == CH_NL) begin
                        line_next = line_inc;
                    end
                    mode_next = MODE_STRING;
                end
                default: mode_next = MODE_IDLE;
            endcase
            if (idle_go) begin
                if (c == CH_NL) begin
                    line_next = line_inc;
                end else if (c == CH_SLASH) begin
                    start_next = line_reg;
                    mode_next  = MODE_SLASH;
                end else if (is_symbol(c) || is_operator(c)) begin
                    start_next = line_reg;
                end else if (c == CH_QUOTE) begin
                    start_next = line_reg;
                    mode_next  = MODE_STRING;
                end else if (is_alpha(c)) begin
                    start_next = line_reg;
                    mode_next  = MODE_IDENT;
                    cand_next  = word_match('1, 4'd0, c);
                    len_next   = 4'd1;
                end else if (is_digit(c)) begin
                    start_next = line_reg;
                    mode_next  = MODE_NUMBER;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= LINE_BITS'(1);
            start_reg <= LINE_BITS'(1);
            cand_reg  <= '1;
            len_reg   <= 4'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
        end
    end

    // closing result goes ahead of the result of the byte itself
    always_comb begin
        push.first  = a_v ? a_res : b_res;
        push.second = b_res;
        push.count  = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
    end

endmodule

/* rtl/core/slx_outq.sv */
// Small result queue taking up to two results per cycle and giving one.
module slx_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  slx_pkg::slx_push_t     push,
    input  logic                   pop,
    output slx_pkg::slx_out_t      head,
    output slx_pkg::slx_q_status_t status
);
    import slx_pkg::*;

    slx_out_t           mem [OUTQ_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0]  level_reg, level_next;
    logic               do_pop;

    assign do_pop      = pop && (level_reg != '0);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
    assign level_next  = level_reg + QLVL_W'(push.count) - QLVL_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head             = mem[rd_ptr_reg];
    assign status.level     = level_reg;
    assign status.has_room  = (level_reg <= QLVL_W'(OUTQ_DEPTH - 2));
    assign status.not_empty = (level_reg != '0);

endmodule

/* rtl/core/source_lexer_token_stream.sv */
// Source lexer top level: one byte item in, token result items out.
// A result is written into the result queue when its byte is accepted and is offered from the queue head.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a token and starts another
// gives two results, so the single output port then sets the pace.
// A four-entry result queue holds up to four results ahead of the consumer.
// Reset (aresetn low, synchronous): idle mode, line one, queue empty.
module source_lexer_token_stream #(
    parameter int LINE_BITS = slx_pkg::LINE_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slx_pkg::slx_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output slx_pkg::slx_out_t m_item
);
    import slx_pkg::*;

    slx_push_t     push;
    slx_q_status_t qstat;
    logic          accept;

    assign s_ready = qstat.has_room;
    assign accept  = s_valid && s_ready;
    assign m_valid = qstat.not_empty;

    slx_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .push    (push)
    );

    slx_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_valid && m_ready),
        .head    (m_item),
        .status  (qstat)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.level <= QLVL_W'(OUTQ_DEPTH))
        else $error("result queue overfilled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    a_empty_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.byte_valid |-> m_item.value_byte == 8'h00)
        else $error("value byte set on a result without a byte");

    a_escape_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.escape_error |-> m_item.token_kind == KIND_STR
                                           && !m_item.byte_valid)
        else $error("escape error outside a string");
`endif

endmodule

/* sim/tb_source_lexer_token_stream.sv */
`timescale 1ns / 1ps
// Testbench for the source lexer: byte streams in, token items checked against a predictor.
module tb_source_lexer_token_stream;
    import slx_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    slx_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    slx_out_t m_item;

    source_lexer_token_stream u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // predicted lexer state
    lex_mode_t         lx_mode;
    logic [31:0]       lx_line;
    logic [31:0]       lx_start;
    logic [NWORDS-1:0] lx_cand;
    logic [3:0]        lx_len;

    string words [NWORDS] = '{
        "func", "struct", "return", "int8", "uint8", "int16", "uint16",
        "int32", "uint32", "int64", "uint64", "float32", "float64", "string"
    };

    slx_out_t exp_tokens [$];
    slx_in_t  pending [$];
    int       mismatches = 0;
    int       cycles     = 0;
    int       items_sent = 0;
    int       rx_wait    = 0;
    bit       gaps_on    = 1'b1;
    bit       stalls_on  = 1'b1;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    // {known, decoded byte}
    function automatic logic [8:0] decode_escape(input logic [7:0] c);
        case (c)
            CH_N:      return {1'b1, CH_NL};
            CH_T:      return {1'b1, CH_TAB};
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            CH_V:      return {1'b1, CH_VT};
            CH_R:      return {1'b1, CH_CR};
            CH_F:      return {1'b1, CH_FF};
            CH_0:      return {1'b1, CH_NUL};
            default:   return {1'b0, CH_NUL};
        endcase
    endfunction

    function automatic logic [2:0] word_class();
        for (int w = 0; w < NWORDS; w++) begin
            if (lx_cand[w] && words[w].len() == lx_len) begin
                return (w < NUM_KEYWORDS) ? KIND_KEY : KIND_PRIM;
            end
        end
        return KIND_ID;
    endfunction

    task automatic match_word_char(input logic [7:0] c);
        for (int w = 0; w < NWORDS; w++) begin
            if (!(lx_len < words[w].len() && words[w][lx_len] == c)) begin
                lx_cand[w] = 1'b0;
            end
        end
        if (lx_len != 4'hF) begin
            lx_len++;
        end
    endtask

    task automatic bump_line();
        if (lx_line != '1) begin
            lx_line++;
        end
    endtask

    task automatic lexer_clear();
        lx_mode  = MODE_IDLE;
        lx_line  = 32'd1;
        lx_start = 32'd1;
        lx_cand  = '1;
        lx_len   = 4'd0;
    endtask

    task automatic push_result(input logic [2:0] kind, input logic [7:0] b, input logic valid,
                               input logic last, input logic err);
        slx_out_t r;
        r.token_kind   = kind;
        r.value_byte   = valid ? b : 8'h00;
        r.byte_valid   = valid;
        r.token_last   = last;
        r.token_line   = lx_start;
        r.escape_error = err;
        exp_tokens.insert(exp_tokens.size(), r);
    endtask

    task automatic start_token(input logic [7:0] c);
        case (c)
            CH_NL: bump_line();
            CH_SLASH: begin
                lx_start = lx_line;
                lx_mode  = MODE_SLASH;
            end
            CH_SEMI, CH_COMMA, CH_LBRACE, CH_RBRACE: begin
                lx_start = lx_line;
                push_result(KIND_SYM, c, 1'b1, 1'b1, 1'b0);
            end
            CH_EQUALS, CH_PLUS, CH_MINUS, CH_STAR, CH_LPAREN, CH_RPAREN: begin
                lx_start = lx_line;
                push_result(KIND_OP, c, 1'b1, 1'b1, 1'b0);
            end
            CH_QUOTE: begin
                lx_start = lx_line;
                lx_mode  = MODE_STRING;
            end
            default: begin
                if (is_letter(c)) begin
                    lx_start = lx_line;
                    lx_mode  = MODE_IDENT;
                    lx_cand  = '1;
                    lx_len   = 4'd0;
                    match_word_char(c);
                    push_result(KIND_ID, c, 1'b1, 1'b0, 1'b0);
                end else if (is_numeral(c)) begin
                    lx_start = lx_line;
                    lx_mode  = MODE_NUMBER;
                    push_result(KIND_NUM, c, 1'b1, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic model_lexer(input logic cmd, input logic [7:0] c);
        logic [8:0] esc;
        logic       rescan;
        rescan = 1'b0;
        if (cmd == CMD_FLUSH) begin
            case (lx_mode)
                MODE_SLASH:  push_result(KIND_OP, CH_SLASH, 1'b1, 1'b1, 1'b0);
                MODE_IDENT:  push_result(word_class(), CH_NUL, 1'b0, 1'b1, 1'b0);
                MODE_NUMBER: push_result(KIND_NUM, CH_NUL, 1'b0, 1'b1, 1'b0);
                MODE_STRING: push_result(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b0);
                MODE_ESC:    push_result(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b1);
                default: ;
            endcase
            lexer_clear();
            return;
        end
        case (lx_mode)
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    lx_mode = MODE_LCOMMENT;
                end else if (c == CH_STAR) begin
                    lx_mode = MODE_BLOCK;
                end else begin
                    push_result(KIND_OP, CH_SLASH, 1'b1, 1'b1, 1'b0);
                    lx_mode = MODE_IDLE;
                    rescan  = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_numeral(c)) begin
                    match_word_char(c);
                    push_result(KIND_ID, c, 1'b1, 1'b0, 1'b0);
                end else begin
                    push_result(word_class(), CH_NUL, 1'b0, 1'b1, 1'b0);
                    lx_mode = MODE_IDLE;
                    rescan  = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_numeral(c) || c == CH_DOT) begin
                    push_result(KIND_NUM, c, 1'b1, 1'b0, 1'b0);
                end else begin
                    push_result(KIND_NUM, CH_NUL, 1'b0, 1'b1, 1'b0);
                    lx_mode = MODE_IDLE;
                    rescan  = 1'b1;
                end
            end
            MODE_LCOMMENT: begin
                if (c == CH_NL) begin
                    bump_line();
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) begin
                    lx_mode = MODE_BSTAR;
                end else if (c == CH_NL) begin
                    bump_line();
                end
            end
            MODE_BSTAR: begin
                if (c == CH_SLASH) begin
                    lx_mode = MODE_IDLE;
                end else if (c != CH_STAR) begin
                    if (c == CH_NL) begin
                        bump_line();
                    end
                    lx_mode = MODE_BLOCK;
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    push_result(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b0);
                    lx_mode = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    lx_mode = MODE_ESC;
                end else begin
                    if (c == CH_NL) begin
                        bump_line();
                    end
                    push_result(KIND_STR, c, 1'b1, 1'b0, 1'b0);
                end
            end
            MODE_ESC: begin
                esc = decode_escape(c);
                if (esc[8]) begin
                    push_result(KIND_STR, esc[7:0], 1'b1, 1'b0, 1'b0);
                end else begin
                    if (c == CH_NL) begin
                        bump_line();
                    end
                    push_result(KIND_STR, CH_NUL, 1'b0, 1'b0, 1'b1);
                end
                lx_mode = MODE_STRING;
            end
            default: begin
                lx_mode = MODE_IDLE;
                rescan  = 1'b1;
            end
        endcase
        if (rescan) begin
            start_token(c);
        end
    endtask

    task automatic check_result(input slx_out_t got);
        slx_out_t want;
        if (exp_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected item: kind %0d byte %h valid %b last %b line %0d err %b",
                         got.token_kind, got.value_byte, got.byte_valid, got.token_last,
                         got.token_line, got.escape_error);
            end
            return;
        end
        want = exp_tokens.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t: expected kind %0d byte %h valid %b last %b line %0d err %b",
                         $realtime, want.token_kind, want.value_byte, want.byte_valid,
                         want.token_last, want.token_line, want.escape_error);
                $display("                 got kind %0d byte %h valid %b last %b line %0d err %b",
                         got.token_kind, got.value_byte, got.byte_valid, got.token_last,
                         got.token_line, got.escape_error);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_item);
            rx_wait = stalls_on ? $urandom_range(0, 5) : 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        m_ready <= aresetn && rx_wait == 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input slx_in_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        model_lexer(it.command, it.char_in);
    endtask

    task automatic add_byte(input logic [7:0] c);
        slx_in_t it;
        it.command = CMD_BYTE;
        it.char_in = c;
        pending.insert(pending.size(), it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task automatic add_flush();
        slx_in_t it;
        it.command = CMD_FLUSH;
        it.char_in = 8'($urandom_range(0, 255));
        pending.insert(pending.size(), it);
    endtask

    task automatic send_pending();
        slx_in_t it;
        while (pending.size() > 0) begin
            it = pending.pop_front();
            send_item(it);
        end
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (exp_tokens.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) begin
            return CH_LA + 8'(r);
        end else if (r < 52) begin
            return CH_UA + 8'(r - 26);
        end
        return CH_0 + 8'(r - 52);
    endfunction

    task automatic send_random_token();
        string punct   = ";,{}=+-*()/";
        string esc_set = "ntvrf0\"\\qx\n";
        string blk_set = "**//ab\n";
        string w;
        int    pick;
        int    n;
        pick = $urandom_range(0, 29);
        if (pick < 4) begin
            w = words[$urandom_range(0, NWORDS - 1)];
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
            add_text(w.substr(0, n - 1));
            if ($urandom_range(0, 3) == 0) begin
                add_byte(rand_alnum());
            end
        end else if (pick < 8) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
            add_byte(w.len() == 0 && $urandom_range(0, 1) ? CH_LA + 8'($urandom_range(0, 25))
                                                            : CH_UA + 8'($urandom_range(0, 25)));
            repeat (n - 1) add_byte(rand_alnum());
        end else if (pick < 11) begin
            add_byte(CH_0 + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 5)) begin
                add_byte($urandom_range(0, 3) == 0 ? CH_DOT : CH_0 + 8'($urandom_range(0, 9)));
            end
        end else if (pick < 14) begin
            add_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                n = $urandom_range(0, 9);
                if (n < 2) begin
                    add_byte(CH_BSLASH);
                    add_byte(n == 0 ? esc_set[$urandom_range(0, esc_set.len() - 1)]
                                    : 8'($urandom_range(0, 255)));
                end else if (n == 2) begin
                    add_byte(CH_NL);
                end else begin
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
            if ($urandom_range(0, 7) != 0) begin
                add_byte(CH_QUOTE);
            end
        end else if (pick < 20) begin
            add_byte(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 22) begin
            add_text("//");
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(8'h20, 8'hFF)));
            add_byte(CH_NL);
        end else if (pick < 24) begin
            add_text("/*");
            repeat ($urandom_range(0, 8)) add_byte(blk_set[$urandom_range(0, blk_set.len() - 1)]);
            add_text("*/");
        end else if (pick < 27) begin
            add_byte($urandom_range(0, 1) ? CH_NL : ($urandom_range(0, 1) ? CH_TAB : 8'h20));
        end else if (pick < 29) begin
            add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_flush();
        end
        send_pending();
    endtask

    task automatic send_random_stream(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            send_random_token();
        end
    endtask

    task automatic test_directed();
        add_text("/*/*/");
        add_text("func(");
        add_byte(CH_QUOTE);
        add_byte(CH_BSLASH);
        add_byte(CH_NL);
        add_byte(CH_BSLASH);
        add_byte(CH_N + 8'h03);
        add_byte(CH_BSLASH);
        add_flush();
        add_text("9.");
        add_byte(8'hFF);
        add_byte(CH_SLASH);
        add_flush();
        add_text("//");
        add_byte(8'h00);
        add_flush();
        send_pending();
    endtask

    task automatic test_mixed_tokens();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_random_stream(1000);
    endtask

    task automatic test_full_rate();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random_stream(400);
    endtask

    task automatic test_slow_consumer();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        send_random_stream(500);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        m_ready <= 1'b0;
        lexer_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_results_done();
        test_mixed_tokens();
        wait_results_done();
        test_full_rate();
        wait_results_done();
        test_slow_consumer();
        wait_results_done();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && exp_tokens.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
